// File: hw/rtl/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared types and constants of the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  // Configuration space: three 32-bit registers at byte offsets 0, 4, 8.
  localparam int unsigned CfgAddrBits = 4;
  localparam int unsigned CfgDataBits = 32;
  localparam int unsigned SizeBits    = 11;

  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_VIEW_COLS = 2'd1,
    REG_VIEW_ROWS = 2'd2
  } reg_idx_e;

  localparam logic [SizeBits-1:0] ViewColsRst = 11'd640;
  localparam logic [SizeBits-1:0] ViewRowsRst = 11'd480;

  // Header byte layout
  localparam int unsigned HdrSyncBit  = 3;
  localparam int unsigned HdrXSignBit = 4;
  localparam int unsigned HdrYSignBit = 5;
  localparam int unsigned HdrXOvfBit  = 6;
  localparam int unsigned HdrYOvfBit  = 7;

  typedef struct packed {
    logic                enable;
    logic [SizeBits-1:0] view_cols;
    logic [SizeBits-1:0] view_rows;
  } cfg_t;

endpackage

// File: hw/rtl/ps2mct_if.sv
// ----------------------------------------------------------------------------
// ps2mct_if
// Valid/ready channels of the tracker: byte words in, cursor words out.
// ----------------------------------------------------------------------------
interface ps2mct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       aux_ready;

  modport source (output valid, output data_byte, output aux_ready, input ready);
  modport sink   (input valid, input data_byte, input aux_ready, output ready);
endinterface

interface ps2mct_out_if #(
  parameter int unsigned COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic                  left_pressed;
  logic                  right_pressed;
  logic                  middle_pressed;
  logic                  packet_done;
  logic                  motion_dropped;

  modport source (
    output valid, output cursor_x, output cursor_y, output left_pressed,
    output right_pressed, output middle_pressed, output packet_done,
    output motion_dropped, input ready
  );
  modport sink (
    input valid, input cursor_x, input cursor_y, input left_pressed,
    input right_pressed, input middle_pressed, input packet_done,
    input motion_dropped, output ready
  );
endinterface

// File: hw/rtl/ps2mct_regs.sv
// ----------------------------------------------------------------------------
// ps2mct_regs
// APB register file: enable, screen width and screen height.
// ----------------------------------------------------------------------------
module ps2mct_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ps2mct_pkg::CfgAddrBits-1:0]  paddr,
  input  logic [ps2mct_pkg::CfgDataBits-1:0]  pwdata,
  output logic [ps2mct_pkg::CfgDataBits-1:0]  prdata,
  output logic                                pready,
  output ps2mct_pkg::cfg_t                    cfg_o
);
  import ps2mct_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[CfgAddrBits-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= 1'b0;
      cfg_q.view_cols <= ViewColsRst;
      cfg_q.view_rows <= ViewRowsRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_ENABLE:    cfg_q.enable    <= pwdata[0];
        REG_VIEW_COLS: cfg_q.view_cols <= pwdata[SizeBits-1:0];
        REG_VIEW_ROWS: cfg_q.view_rows <= pwdata[SizeBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE:    prdata = {{(CfgDataBits-1){1'b0}}, cfg_q.enable};
      REG_VIEW_COLS: prdata = {{(CfgDataBits-SizeBits){1'b0}}, cfg_q.view_cols};
      REG_VIEW_ROWS: prdata = {{(CfgDataBits-SizeBits){1'b0}}, cfg_q.view_rows};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/ps2mct_tracker.sv
// ----------------------------------------------------------------------------
// ps2mct_tracker
// Packet framing and cursor state; computes the next cursor word per byte.
// ----------------------------------------------------------------------------
module ps2mct_tracker #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ps2mct_pkg::cfg_t      cfg_i,
  input  logic                  adv_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  aux_ready_i,
  output logic [COORD_BITS-1:0] cursor_x_o,
  output logic [COORD_BITS-1:0] cursor_y_o,
  output logic [2:0]            buttons_o,
  output logic                  packet_done_o,
  output logic                  motion_dropped_o
);
  import ps2mct_pkg::*;

  localparam int unsigned SumBits = COORD_BITS + 2;
  localparam int unsigned LimBits = ((COORD_BITS > SizeBits) ? COORD_BITS : SizeBits) + 1;
  localparam logic [LimBits-1:0] MaxSize = LimBits'(1) << COORD_BITS;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_XMOVE  = 2'd1,
    PH_YMOVE  = 2'd2
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [7:0]            header_q, header_d;
  logic [7:0]            xmove_q, xmove_d;
  logic [COORD_BITS-1:0] pos_x_q, pos_x_d;
  logic [COORD_BITS-1:0] pos_y_q, pos_y_d;
  logic [2:0]            btn_q, btn_d;
  logic                  done, dropped, ovf;

  logic signed [8:0]         dx, dy;
  logic signed [SumBits-1:0] nx, ny;
  logic [COORD_BITS-1:0]     lim_x, lim_y;

  function automatic logic [COORD_BITS-1:0] size_limit(input logic [SizeBits-1:0] size);
    logic [LimBits-1:0] s;
    s = LimBits'(size);
    if (s == '0) s = LimBits'(1);
    if (s > MaxSize) s = MaxSize;
    s = s - LimBits'(1);
    return s[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SumBits-1:0] v,
                                                  input logic [COORD_BITS-1:0] hi);
    logic [COORD_BITS-1:0] r;
    if (v < 0) r = '0;
    else if (v > $signed({2'b00, hi})) r = hi;
    else r = v[COORD_BITS-1:0];
    return r;
  endfunction

  assign ovf   = header_q[HdrXOvfBit] | header_q[HdrYOvfBit];
  assign dx    = $signed({header_q[HdrXSignBit], xmove_q});
  assign dy    = $signed({header_q[HdrYSignBit], data_byte_i});
  assign nx    = $signed({2'b00, pos_x_q}) + SumBits'(dx);
  assign ny    = $signed({2'b00, pos_y_q}) - SumBits'(dy);
  assign lim_x = size_limit(cfg_i.view_cols);
  assign lim_y = size_limit(cfg_i.view_rows);

  always_comb begin
    phase_d  = phase_q;
    header_d = header_q;
    xmove_d  = xmove_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    btn_d    = btn_q;
    done     = 1'b0;
    dropped  = 1'b0;
    if (aux_ready_i) begin
      unique case (phase_q)
        PH_XMOVE: begin
          xmove_d = data_byte_i;
          phase_d = PH_YMOVE;
        end
        PH_YMOVE: begin
          done    = 1'b1;
          dropped = ovf;
          if (cfg_i.enable) begin
            if (!ovf) begin
              pos_x_d = clamp(nx, lim_x);
              pos_y_d = clamp(ny, lim_y);
            end
            btn_d = header_q[2:0];
          end
          phase_d = PH_HEADER;
        end
        default: begin
          // wait for a byte with the sync bit before framing
          if (data_byte_i[HdrSyncBit]) begin
            header_d = data_byte_i;
            phase_d  = PH_XMOVE;
          end else begin
            phase_d  = PH_HEADER;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      header_q <= '0;
      xmove_q  <= '0;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      btn_q    <= '0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      header_q <= header_d;
      xmove_q  <= xmove_d;
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      btn_q    <= btn_d;
    end
  end

  assign cursor_x_o       = pos_x_d;
  assign cursor_y_o       = pos_y_d;
  assign buttons_o        = btn_d;
  assign packet_done_o    = done;
  assign motion_dropped_o = dropped;

endmodule

// File: hw/rtl/ps2_mouse_cursor_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// Frames three-byte PS/2 mouse packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// channel  dir  handshake        word
// in_i     in   valid/ready      data_byte, aux_ready
// out_o    out  valid/ready      cursor_x/y, buttons, packet_done, motion_dropped
// apb      in   psel/penable     enable, view columns, view rows
//
// One word per cycle sustained while out_o is ready; a word taken at in_i passes
// the input register, then the result register after the add and clamp, to out_o.
// Reset clears framing, cursor and buttons; registers go to 0 / 640 / 480.
// A stalled out_o holds its word; in_i keeps accepting until both stages fill.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  ps2mct_in_if.sink                           in_i,
  ps2mct_out_if.source                        out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ps2mct_pkg::CfgAddrBits-1:0]  paddr,
  input  logic [ps2mct_pkg::CfgDataBits-1:0]  pwdata,
  output logic [ps2mct_pkg::CfgDataBits-1:0]  prdata,
  output logic                                pready
);
  import ps2mct_pkg::*;

  cfg_t cfg;

  logic       s1_valid_q;
  logic [7:0] s1_data_q;
  logic       s1_aux_q;
  logic       s1_adv;
  logic       in_fire;

  logic                  out_valid_q;
  logic [COORD_BITS-1:0] x_d, y_d, x_q, y_q;
  logic [2:0]            btn_d, btn_q;
  logic                  done_d, done_q, drop_d, drop_q;

  ps2mct_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ps2mct_tracker #(.COORD_BITS(COORD_BITS)) u_tracker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .adv_i            (s1_adv),
    .data_byte_i      (s1_data_q),
    .aux_ready_i      (s1_aux_q),
    .cursor_x_o       (x_d),
    .cursor_y_o       (y_d),
    .buttons_o        (btn_d),
    .packet_done_o    (done_d),
    .motion_dropped_o (drop_d)
  );

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_i.data_byte;
      s1_aux_q  <= in_i.aux_ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      x_q    <= x_d;
      y_q    <= y_d;
      btn_q  <= btn_d;
      done_q <= done_d;
      drop_q <= drop_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.cursor_x       = x_q;
  assign out_o.cursor_y       = y_q;
  assign out_o.left_pressed   = btn_q[0];
  assign out_o.right_pressed  = btn_q[1];
  assign out_o.middle_pressed = btn_q[2];
  assign out_o.packet_done    = done_q;
  assign out_o.motion_dropped = drop_q;

  // a dropped-motion flag only ever rides on a completed packet
  a_drop_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (!out_o.motion_dropped || out_o.packet_done))
    else $error("motion_dropped without packet_done");

  // both stages full and output stalled: input must back off
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while pipeline full");

  // a word leaving the input stage lands in the result register
  a_adv_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced word lost");

endmodule
